FILE: hw/rtl/a2oct_pkg.sv
// Shared types and constants for the ASCII-to-octal converter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package a2oct_pkg;

    localparam int VALUE_W  = 24;          // accumulator width, wraps modulo 2^24
    localparam int GROUPS   = VALUE_W / 3; // octal digits in the accumulator
    localparam int GROUP_W  = 3;
    localparam int M_W      = 4;           // holds 0..GROUPS

    // input_base register codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;
    localparam logic [1:0] BASE_BAD = 2'd3;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    // result kind carried on tuser
    localparam logic KIND_DIGIT = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic load;     // a character request is taken this cycle
        logic calc;     // set up the first result from the accumulated number
        logic advance;  // current result taken, move to the next digit
    } a2oct_cmd_t;

    typedef struct packed {
        logic last;     // result on the output is the last of its run
    } a2oct_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    function automatic digit_t decode_digit(input logic [7:0] ch, input logic [1:0] base);
        digit_t d;
        d.ok    = 1'b0;
        d.value = 4'd0;
        case (base)
            BASE_BIN: begin
                if (ch == CH_0 || ch == CH_1) begin
                    d.ok    = 1'b1;
                    d.value = 4'(ch - CH_0);
                end
            end
            BASE_DEC: begin
                if (ch >= CH_0 && ch <= CH_9) begin
                    d.ok    = 1'b1;
                    d.value = 4'(ch - CH_0);
                end
            end
            BASE_HEX: begin
                if (ch >= CH_0 && ch <= CH_9) begin
                    d.ok    = 1'b1;
                    d.value = 4'(ch - CH_0);
                end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
                    d.ok    = 1'b1;
                    d.value = 4'(ch - CH_UP_A) + 4'd10;
                end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
                    d.ok    = 1'b1;
                    d.value = 4'(ch - CH_LO_A) + 4'd10;
                end
            end
            default: begin
                d.ok = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ascii_number_to_octal_digits_top.sv
// Top level of the ASCII-to-octal converter: controller plus datapath.
// Depends on a2oct_pkg, a2oct_ctrl and a2oct_dp.
`default_nettype none

// Takes the ASCII characters of one number (most significant first, tlast on
// the last one) in the base held by the input_base register (0 binary,
// 1 decimal, 2 hex in either case) and returns either one "number is wrong"
// result or a leading octal zero followed by the octal digits, most
// significant first; m_tlast marks the last result of the number. Only the
// first MAX_DIGITS characters are checked and used. Non-final characters are
// taken back to back. A final character is taken, the results are set up,
// then the 1 + m results (m up to 8) leave, held while m_tready is low; the
// block takes no new character while results of a number are pending.
// Write input_base only while idle.
module ascii_number_to_octal_digits_top #(
    parameter int MAX_DIGITS = 6
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,   // input_base
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] character
    input  wire logic       s_tlast,       // final_char
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [2:0] octal_digit, [7:3] zero
    output logic            m_tuser,       // [0] kind
    output logic            m_tlast        // end_of_run
);

    a2oct_pkg::a2oct_cmd_t    cmd;
    a2oct_pkg::a2oct_status_t status;
    logic [2:0]               octal_digit;

    a2oct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    a2oct_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .character   (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .kind        (m_tuser),
        .octal_digit (octal_digit),
        .end_of_run  (m_tlast)
    );

    assign m_tdata = {5'b00000, octal_digit};

endmodule

`default_nettype wire

FILE: hw/rtl/a2oct_ctrl.sv
// Controller for the ASCII-to-octal converter: sequences character intake,
// result setup and digit emission. Depends on a2oct_pkg.
`default_nettype none

module a2oct_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tlast,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    input  wire a2oct_pkg::a2oct_status_t status,
    output a2oct_pkg::a2oct_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.load    = s_tvalid & s_tready_reg;
        cmd.calc    = (state_reg == ST_CALC);
        cmd.advance = m_tvalid_reg & m_tready & ~status.last;
    end

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tlast) begin
                    state_next    = ST_CALC;
                    s_tready_next = 1'b0;
                end
            end
            ST_CALC: begin
                state_next    = ST_OUT;
                m_tvalid_next = 1'b1;
            end
            ST_OUT: begin
                if (m_tready && status.last) begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                    m_tvalid_next = 1'b0;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/a2oct_dp.sv
// Datapath for the ASCII-to-octal converter: base register, accumulator,
// digit counter and result registers. Depends on a2oct_pkg.
`default_nettype none

module a2oct_dp #(
    parameter int MAX_DIGITS = 6
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_wr_data,
    input  wire logic [7:0]              character,
    input  wire a2oct_pkg::a2oct_cmd_t   cmd,
    output a2oct_pkg::a2oct_status_t     status,
    output logic                         kind,
    output logic [2:0]                   octal_digit,
    output logic                         end_of_run
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [1:0]                      base_reg;
    logic [a2oct_pkg::VALUE_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            bad_reg, bad_next;
    logic [a2oct_pkg::VALUE_W-1:0]   val_reg;
    logic [a2oct_pkg::M_W-1:0]       idx_reg, idx_next;
    logic                            kind_reg, kind_next;
    logic [2:0]                      digit_reg, digit_next;
    logic                            end_reg, end_next;

    a2oct_pkg::digit_t               dig;
    logic [a2oct_pkg::VALUE_W-1:0]   scaled;
    logic [a2oct_pkg::M_W-1:0]       m_dec;
    logic [a2oct_pkg::M_W-1:0]       m_bin;
    logic [a2oct_pkg::M_W-1:0]       m_sel;
    logic                            err;
    logic [a2oct_pkg::M_W-1:0]       count_ext;
    logic [2:0]                      next_pos;
    logic [2:0]                      next_group;

    assign status.last = end_reg;
    assign kind        = kind_reg;
    assign octal_digit = digit_reg;
    assign end_of_run  = end_reg;

    assign dig = a2oct_pkg::decode_digit(character, base_reg);

    always_comb begin
        case (base_reg)
            a2oct_pkg::BASE_BIN: scaled = {acc_reg[a2oct_pkg::VALUE_W-2:0], 1'b0};
            a2oct_pkg::BASE_DEC: scaled = {acc_reg[a2oct_pkg::VALUE_W-4:0], 3'b000}
                                        + {acc_reg[a2oct_pkg::VALUE_W-2:0], 1'b0};
            default:             scaled = {acc_reg[a2oct_pkg::VALUE_W-5:0], 4'b0000};
        endcase
    end

    // Fold a character in; characters past MAX_DIGITS are ignored entirely.
    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        if (cmd.calc) begin
            acc_next   = '0;
            count_next = '0;
            bad_next   = 1'b0;
        end else if (cmd.load && count_reg < CNT_W'(MAX_DIGITS)) begin
            count_next = count_reg + 1'b1;
            if (dig.ok) begin
                acc_next = scaled + a2oct_pkg::VALUE_W'(dig.value);
            end else begin
                bad_next = 1'b1;
            end
        end
    end

    // Octal digit counts: minimal for decimal/hex, ceil(n/3) for binary.
    always_comb begin
        m_dec = '0;
        for (int k = 0; k < a2oct_pkg::GROUPS; k++) begin
            if (acc_reg[k*a2oct_pkg::GROUP_W +: a2oct_pkg::GROUP_W] != 3'd0) begin
                m_dec = a2oct_pkg::M_W'(k + 1);
            end
        end
    end

    assign count_ext = a2oct_pkg::M_W'(count_reg);

    always_comb begin
        case (count_ext)
            4'd0:                m_bin = 4'd0;
            4'd1, 4'd2, 4'd3:    m_bin = 4'd1;
            4'd4, 4'd5, 4'd6:    m_bin = 4'd2;
            default:             m_bin = 4'd3;
        endcase
    end

    assign m_sel = (base_reg == a2oct_pkg::BASE_BIN) ? m_bin : m_dec;
    assign err   = bad_reg || (base_reg == a2oct_pkg::BASE_BAD);

    assign next_pos = 3'(idx_reg - 1'b1);

    always_comb begin
        next_group = 3'd0;
        for (int k = 0; k < a2oct_pkg::GROUPS; k++) begin
            if (next_pos == 3'(k)) begin
                next_group = val_reg[k*a2oct_pkg::GROUP_W +: a2oct_pkg::GROUP_W];
            end
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        digit_next = digit_reg;
        end_next   = end_reg;
        if (cmd.calc) begin
            // first result: error marker or the leading octal zero
            kind_next  = err ? a2oct_pkg::KIND_ERROR : a2oct_pkg::KIND_DIGIT;
            digit_next = 3'd0;
            end_next   = err || (m_sel == '0);
            idx_next   = m_sel;
        end else if (cmd.advance) begin
            kind_next  = a2oct_pkg::KIND_DIGIT;
            digit_next = next_group;
            end_next   = (idx_reg == a2oct_pkg::M_W'(1));
            idx_next   = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= a2oct_pkg::BASE_DEC;
            acc_reg   <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            acc_reg   <= acc_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            val_reg <= acc_reg;
        end
        idx_reg   <= idx_next;
        kind_reg  <= kind_next;
        digit_reg <= digit_next;
        end_reg   <= end_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/a2oct_checker.sv
// Port-level checks for ascii_number_to_octal_digits_top, attached by bind.
// No package dependencies.
`default_nettype none

module a2oct_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // one number at a time: intake is closed while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // an error result stands alone with a zero digit
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
        else $error("error result not alone");

    // taking the last character closes intake
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("intake still open after final character");

    // after the last result is taken, no further result follows at once
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result after end of run");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind ascii_number_to_octal_digits_top a2oct_checker u_a2oct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
